/* rtl/core/cfa_pkg.sv */
// Shared types and constants of the car-following acceleration core.
// No dependencies; every other file of the core but cfa_checker uses this package.
`default_nettype none
package cfa_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned DIV_NUM_W = 49;
   localparam int unsigned DIV_DEN_W = 34;

   localparam logic [CSR_ADDR_W-1:0] REG_DESIRED_SPEED  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SPEED_EXPONENT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_ACCEL      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_GAP        = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_TIME_HEADWAY   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_COMFORT_TERM   = 3'd5;

   localparam logic [15:0] RST_DESIRED_SPEED  = 16'd7680;
   localparam logic [3:0]  RST_SPEED_EXPONENT = 4'd4;
   localparam logic [15:0] RST_MAX_ACCEL      = 16'd256;
   localparam logic [15:0] RST_MIN_GAP        = 16'd512;
   localparam logic [15:0] RST_TIME_HEADWAY   = 16'd384;
   localparam logic [15:0] RST_COMFORT_TERM   = 16'd314;

   // Free road: leader at 25 m/s, 500 m ahead (Q8.8).
   localparam logic [15:0] FREE_LEADER_SPEED = 16'd6400;
   localparam logic [32:0] FREE_GAP          = 33'd128000;

   localparam logic [32:0] ONE_Q16  = 33'h0_0001_0000;
   localparam logic [32:0] TERM_CAP = 33'h1_0000_0000;
   localparam logic [48:0] RATIO_LIMIT = 49'h1_000000;

   typedef struct packed {
      logic [15:0] desired_speed;
      logic [3:0]  speed_exponent;
      logic [15:0] max_accel;
      logic [15:0] min_gap;
      logic [15:0] time_headway;
      logic [15:0] comfort_term;
   } cfg_type;

   typedef struct packed {
      logic        gap_fault;
      logic [15:0] own_speed;
      logic [15:0] leader_speed;
      logic [32:0] gap;
   } item_type;

endpackage
`default_nettype wire

/* rtl/core/cfa_front.sv */
// Front end: classifies one incoming word into a queue item (gap, leader speed, fault).
// Depends on cfa_pkg.
`default_nettype none
module cfa_front (
   input  wire logic               leader_present,
   input  wire logic [15:0]        own_speed,
   input  wire logic [15:0]        leader_speed,
   input  wire logic signed [31:0] own_position,
   input  wire logic signed [31:0] leader_position,
   input  wire logic               travel_reverse,
   input  wire logic [15:0]        own_length,
   output cfa_pkg::item_type       item
);
   import cfa_pkg::*;

   logic signed [32:0] diff;
   logic signed [33:0] dir_diff;
   logic signed [34:0] gap_full;

   always_comb begin
      diff     = $signed({leader_position[31], leader_position})
               - $signed({own_position[31], own_position});
      dir_diff = travel_reverse ? -$signed({diff[32], diff}) : $signed({diff[32], diff});
      gap_full = $signed({dir_diff[33], dir_diff}) - $signed({19'b0, own_length});

      item.own_speed = own_speed;
      if (leader_present) begin
         item.leader_speed = leader_speed;
         item.gap          = gap_full[32:0];
         item.gap_fault    = gap_full[34] || (gap_full == 35'sd0);
      end else begin
         item.leader_speed = FREE_LEADER_SPEED;
         item.gap          = FREE_GAP;
         item.gap_fault    = 1'b0;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/cfa_queue.sv */
// Small FIFO of classified items between the front end and the back end.
// Depends on cfa_pkg.
`default_nettype none
module cfa_queue #(
   parameter int unsigned DEPTH = cfa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire cfa_pkg::item_type wdata,
   output logic              full,
   input  wire logic         pop,
   output cfa_pkg::item_type rdata,
   output logic              empty
);
   import cfa_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/cfa_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on cfa_pkg for its default widths.
`default_nettype none
module cfa_div #(
   parameter int unsigned NUM_W = cfa_pkg::DIV_NUM_W,
   parameter int unsigned DEN_W = cfa_pkg::DIV_DEN_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quo
);
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_ff, rem_sh, rem_next;
   logic [DEN_W+1:0] trial;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff, ge;

   assign done = done_ff;
   assign quo  = quo_ff;

   always_comb begin
      rem_sh   = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      trial    = {1'b0, rem_sh} - {2'b0, den_ff};
      ge       = !trial[DEN_W+1];
      rem_next = ge ? trial[DEN_W:0] : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff <= rem_next;
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

endmodule
`default_nettype wire

/* rtl/core/cfa_back.sv */
// Back end: sequencer that evaluates one item with a shared multiplier and divider,
// and holds the finished result word. Depends on cfa_pkg and cfa_div.
`default_nettype none
module cfa_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfa_pkg::cfg_type  cfg,
   input  wire cfa_pkg::item_type q_item,
   input  wire logic         q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic signed [15:0] rsp_accel_out,
   output logic              rsp_gap_fault
);
   import cfa_pkg::*;

   localparam logic [4:0] ST_IDLE        = 5'd0;
   localparam logic [4:0] ST_MUL_DV      = 5'd1;
   localparam logic [4:0] ST_DIV_DV_GO   = 5'd2;
   localparam logic [4:0] ST_DIV_DV_WAIT = 5'd3;
   localparam logic [4:0] ST_MUL_TH      = 5'd4;
   localparam logic [4:0] ST_WANT        = 5'd5;
   localparam logic [4:0] ST_P_CHECK     = 5'd6;
   localparam logic [4:0] ST_P_DIV_GO    = 5'd7;
   localparam logic [4:0] ST_P_DIV_WAIT  = 5'd8;
   localparam logic [4:0] ST_G_DIV_GO    = 5'd9;
   localparam logic [4:0] ST_G_DIV_WAIT  = 5'd10;
   localparam logic [4:0] ST_G_SQ        = 5'd11;
   localparam logic [4:0] ST_G_TERM      = 5'd12;
   localparam logic [4:0] ST_S_CALC      = 5'd13;
   localparam logic [4:0] ST_A_MUL       = 5'd14;
   localparam logic [4:0] ST_A_OUT       = 5'd15;
   localparam logic [4:0] ST_DONE        = 5'd16;

   localparam logic signed [35:0] S_FLOOR = -36'sh1_0000_0000;

   logic [4:0]  state_ff, state_in;
   item_type    cur_ff;
   logic [58:0] prod_ff;
   logic [33:0] mul_a;
   logic [24:0] mul_b;
   logic [58:0] prod;

   logic                dv_neg_ff;
   logic signed [34:0]  extra_ff;
   logic [32:0]         want_ff, p_ff, q_ff, smag_ff;
   logic [24:0]         r_ff;
   logic [3:0]          cnt_ff;
   logic                s_neg_ff;
   logic signed [15:0]  res_accel_ff;
   logic                res_fault_ff;
   logic                out_valid_ff;
   logic signed [15:0]  out_accel_ff;
   logic                out_fault_ff;

   logic [16:0] dv, dv_mag;
   logic [15:0] v, v0_eff, ct_eff;
   logic signed [35:0] want_sum, s_raw, s_lim, s_abs;
   logic [32:0] m_abs;

   logic              div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_quo;
   logic [DIV_DEN_W-1:0] div_den;
   logic              out_load;

   assign v      = cur_ff.own_speed;
   assign dv     = {1'b0, v} - {1'b0, cur_ff.leader_speed};
   assign dv_mag = dv[16] ? 17'd0 - dv : dv;
   assign v0_eff = (cfg.desired_speed == 16'd0) ? 16'd1 : cfg.desired_speed;
   assign ct_eff = (cfg.comfort_term == 16'd0) ? 16'd1 : cfg.comfort_term;

   // Shared multiplier, registered every cycle.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_DV: begin
            mul_a = {17'b0, dv_mag};
            mul_b = {9'b0, v};
         end
         ST_MUL_TH: begin
            mul_a = {18'b0, cfg.time_headway};
            mul_b = {9'b0, v};
         end
         ST_P_CHECK: begin
            mul_a = {1'b0, p_ff};
            mul_b = {9'b0, v};
         end
         ST_G_SQ: begin
            mul_a = {9'b0, r_ff};
            mul_b = r_ff;
         end
         ST_A_MUL: begin
            mul_a = {1'b0, smag_ff};
            mul_b = {9'b0, cfg.max_accel};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = {25'b0, mul_a} * {34'b0, mul_b};

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (state_ff)
         ST_DIV_DV_GO: begin
            div_start = 1'b1;
            div_num   = {16'b0, prod_ff[32:0]};
            div_den   = {17'b0, ct_eff, 1'b0};
         end
         ST_P_DIV_GO: begin
            div_start = 1'b1;
            div_num   = prod_ff[48:0];
            div_den   = {18'b0, v0_eff};
         end
         ST_G_DIV_GO: begin
            div_start = 1'b1;
            div_num   = {want_ff, 16'b0};
            div_den   = {1'b0, cur_ff.gap};
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   cfa_div #(
      .NUM_W(DIV_NUM_W),
      .DEN_W(DIV_DEN_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quo  (div_quo)
   );

   always_comb begin
      want_sum = $signed({20'b0, cfg.min_gap}) + $signed({12'b0, prod_ff[31:8]})
               + $signed({extra_ff[34], extra_ff});
      s_raw    = $signed(36'd65536) - $signed({3'b0, p_ff}) - $signed({3'b0, q_ff});
      s_lim    = (s_raw < S_FLOOR) ? S_FLOOR : s_raw;
      s_abs    = s_lim[35] ? 36'sd0 - s_lim : s_lim;
      m_abs    = prod_ff[48:16];
   end

   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign out_load = (state_ff == ST_DONE) && (!out_valid_ff || rsp_pop);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = q_item.gap_fault ? ST_DONE : ST_MUL_DV;
            end
         end
         ST_MUL_DV:      state_in = ST_DIV_DV_GO;
         ST_DIV_DV_GO:   state_in = ST_DIV_DV_WAIT;
         ST_DIV_DV_WAIT: state_in = div_done ? ST_MUL_TH : ST_DIV_DV_WAIT;
         ST_MUL_TH:      state_in = ST_WANT;
         ST_WANT:        state_in = ST_P_CHECK;
         ST_P_CHECK:     state_in = (cnt_ff == 4'd0) ? ST_G_DIV_GO : ST_P_DIV_GO;
         ST_P_DIV_GO:    state_in = ST_P_DIV_WAIT;
         ST_P_DIV_WAIT:  state_in = div_done ? ST_P_CHECK : ST_P_DIV_WAIT;
         ST_G_DIV_GO:    state_in = ST_G_DIV_WAIT;
         ST_G_DIV_WAIT: begin
            if (div_done) begin
               state_in = (div_quo > RATIO_LIMIT) ? ST_S_CALC : ST_G_SQ;
            end
         end
         ST_G_SQ:        state_in = ST_G_TERM;
         ST_G_TERM:      state_in = ST_S_CALC;
         ST_S_CALC:      state_in = ST_A_MUL;
         ST_A_MUL:       state_in = ST_A_OUT;
         ST_A_OUT:       state_in = ST_DONE;
         ST_DONE:        state_in = out_load ? ST_IDLE : ST_DONE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_load || (out_valid_ff && !rsp_pop);
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod;
      case (state_ff)
         ST_IDLE: begin
            cur_ff       <= q_item;
            res_accel_ff <= 16'sh8000;
            res_fault_ff <= 1'b1;
         end
         ST_MUL_DV: begin
            dv_neg_ff <= dv[16];
         end
         ST_DIV_DV_WAIT: begin
            extra_ff <= dv_neg_ff ? 35'sd0 - $signed({2'b0, div_quo[32:0]})
                                  : $signed({2'b0, div_quo[32:0]});
         end
         ST_WANT: begin
            want_ff <= (want_sum < $signed({20'b0, cfg.min_gap})) ? {17'b0, cfg.min_gap}
                                                                 : want_sum[32:0];
            p_ff    <= ONE_Q16;
            cnt_ff  <= cfg.speed_exponent;
         end
         ST_P_DIV_WAIT: begin
            if (div_done) begin
               p_ff   <= (div_quo > {16'b0, TERM_CAP}) ? TERM_CAP : div_quo[32:0];
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
         ST_G_DIV_WAIT: begin
            q_ff <= TERM_CAP;
            r_ff <= div_quo[24:0];
         end
         ST_G_TERM: begin
            q_ff <= prod_ff[48:16];
         end
         ST_S_CALC: begin
            s_neg_ff <= s_lim[35];
            smag_ff  <= s_abs[32:0];
         end
         ST_A_OUT: begin
            res_fault_ff <= 1'b0;
            if (s_neg_ff) begin
               res_accel_ff <= (m_abs > 33'd32768) ? 16'sh8000
                                                    : $signed(16'd0 - m_abs[15:0]);
            end else begin
               res_accel_ff <= (m_abs > 33'd32767) ? 16'sh7fff : $signed(m_abs[15:0]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_accel_ff <= res_accel_ff;
         out_fault_ff <= res_fault_ff;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_accel_out = out_accel_ff;
   assign rsp_gap_fault = out_fault_ff;

endmodule
`default_nettype wire

/* rtl/core/car_following_acceleration_core.sv */
// Top level of the car-following acceleration core: configuration registers,
// front end, item queue and back end. Depends on cfa_pkg, cfa_front, cfa_queue, cfa_back and cfa_div.
//
// Usage. The request side behaves like a queue: drive the vehicle-pair word on the
// req_ ports and raise req_push; the word is taken at a clock edge where req_full
// is low. The response side is a queue as well: while rsp_empty is low the oldest
// result word (rsp_accel_out, rsp_gap_fault) is on the rsp_ ports, and it is taken
// at an edge where rsp_pop is high.
// The front end classifies each word in the cycle it is accepted (gap, free-road
// substitution, gap fault) and stores it in a small queue, so requests keep being
// accepted while the back end works and while a result waits to be popped.
// The back end handles one word at a time with one shared multiplier and one
// bit-serial 49-bit divider.
// A gap-fault word skips the arithmetic and goes straight to the result slot;
// a normal word takes one divide for the speed difference term, one per exponent
// step and one for the gap ratio, and skips the squaring when the ratio is capped.
// The back end takes the next word from the queue only after the last result
// has been loaded into the result slot.
// Configuration writes (csr_we, csr_addr, csr_wdata) take effect at the next edge
// and must only be issued while the block is idle.
// Reset is synchronous and active high: queues and result empty, registers at
// their defaults. A stalled receiver fills the result slot, then the queue, and
// then req_full rises; nothing is dropped.
`default_nettype none
module car_following_acceleration_core #(
   parameter int unsigned QUEUE_DEPTH = cfa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [15:0]                     req_own_speed,
   input  wire logic                            req_leader_present,
   input  wire logic [15:0]                     req_leader_speed,
   input  wire logic signed [31:0]              req_own_position,
   input  wire logic signed [31:0]              req_leader_position,
   input  wire logic                            req_travel_reverse,
   input  wire logic [15:0]                     req_own_length,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic signed [15:0]                   rsp_accel_out,
   output logic                                 rsp_gap_fault,
   input  wire logic                            csr_we,
   input  wire logic [cfa_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [15:0]                     csr_wdata
);
   import cfa_pkg::*;

   cfg_type  cfg_ff;
   item_type front_item, q_item;
   logic     q_empty, q_pop;

   // Configuration registers; writes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.desired_speed  <= RST_DESIRED_SPEED;
         cfg_ff.speed_exponent <= RST_SPEED_EXPONENT;
         cfg_ff.max_accel      <= RST_MAX_ACCEL;
         cfg_ff.min_gap        <= RST_MIN_GAP;
         cfg_ff.time_headway   <= RST_TIME_HEADWAY;
         cfg_ff.comfort_term   <= RST_COMFORT_TERM;
      end else if (csr_we) begin
         case (csr_addr)
            REG_DESIRED_SPEED:  cfg_ff.desired_speed  <= csr_wdata;
            REG_SPEED_EXPONENT: cfg_ff.speed_exponent <= csr_wdata[3:0];
            REG_MAX_ACCEL:      cfg_ff.max_accel      <= csr_wdata;
            REG_MIN_GAP:        cfg_ff.min_gap        <= csr_wdata;
            REG_TIME_HEADWAY:   cfg_ff.time_headway   <= csr_wdata;
            REG_COMFORT_TERM:   cfg_ff.comfort_term   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   cfa_front u_front (
      .leader_present (req_leader_present),
      .own_speed      (req_own_speed),
      .leader_speed   (req_leader_speed),
      .own_position   (req_own_position),
      .leader_position(req_leader_position),
      .travel_reverse (req_travel_reverse),
      .own_length     (req_own_length),
      .item           (front_item)
   );

   cfa_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push (req_push),
      .wdata(front_item),
      .full (req_full),
      .pop  (q_pop),
      .rdata(q_item),
      .empty(q_empty)
   );

   cfa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_item       (q_item),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_accel_out(rsp_accel_out),
      .rsp_gap_fault(rsp_gap_fault)
   );

endmodule
`default_nettype wire

/* rtl/core/cfa_checker.sv */
// Port-level checks of the car-following acceleration core, bound to the top level.
// Depends on car_following_acceleration_core.
`default_nettype none
module cfa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [15:0] rsp_accel_out,
   input wire logic        rsp_gap_fault
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request queue full after reset");

   a_fault_value: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_gap_fault) |-> (rsp_accel_out == 16'h8000))
      else $error("gap fault word without most negative acceleration");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_accel_out)
                                    && $stable(rsp_gap_fault)))
      else $error("waiting result word changed");

endmodule

bind car_following_acceleration_core cfa_checker u_cfa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_full     (req_full),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_accel_out(rsp_accel_out),
   .rsp_gap_fault(rsp_gap_fault)
);
`default_nettype wire

/* sim/tb_car_following_acceleration_core.sv */
// Self-checking testbench of the car-following acceleration core.
// Depends on cfa_pkg and car_following_acceleration_core, and through it on the rest of the core.
`default_nettype none
module tb_car_following_acceleration_core;
   import cfa_pkg::*;

   // Settle time after the last result; it and the run limit are sized from the
   // slowest normal word in the back end (speed exponent 15).
   localparam int SETTLE_CYCLES = 1200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [15:0] req_own_speed = '0;
   logic req_leader_present = 1'b0;
   logic [15:0] req_leader_speed = '0;
   logic signed [31:0] req_own_position = '0;
   logic signed [31:0] req_leader_position = '0;
   logic req_travel_reverse = 1'b0;
   logic [15:0] req_own_length = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [15:0] rsp_accel_out;
   logic rsp_gap_fault;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   typedef struct packed {
      logic signed [15:0] accel;
      logic fault;
   } accel_word_type;

   // Predictor's own copy of the configuration registers.
   cfg_type shadow_cfg;
   accel_word_type pending_accel[$];
   int failures = 0;
   int send_idle_pct = 0;
   int pop_stall_pct = 0;

   car_following_acceleration_core uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_own_speed(req_own_speed), .req_leader_present(req_leader_present),
      .req_leader_speed(req_leader_speed), .req_own_position(req_own_position),
      .req_leader_position(req_leader_position),
      .req_travel_reverse(req_travel_reverse), .req_own_length(req_own_length),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_accel_out(rsp_accel_out), .rsp_gap_fault(rsp_gap_fault),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Fixed-point model of the car-following law. All terms are held in
   // 64-bit signed arithmetic, which covers every intermediate value.
   function automatic accel_word_type model_accel(
      input logic [15:0] v_in, input logic present, input logic [15:0] vl_in,
      input logic signed [31:0] own_x, input logic signed [31:0] lead_x,
      input logic reverse, input logic [15:0] length);
      longint v, vl, gap, want, extra, b2, p, q, r, acc, v0, diff;
      accel_word_type w;
      v = v_in;
      if (present) begin
         diff = longint'(lead_x) - longint'(own_x);
         if (reverse) diff = -diff;
         gap = diff - longint'(length);
         vl = vl_in;
         if (gap <= 0) begin
            w.accel = 16'sh8000;
            w.fault = 1'b1;
            return w;
         end
      end else begin
         gap = 128000;
         vl = 6400;
      end
      b2 = 2 * ((shadow_cfg.comfort_term != 0) ? longint'(shadow_cfg.comfort_term) : 1);
      extra = (v * (v - vl)) / b2;
      want = longint'(shadow_cfg.min_gap) + (v * longint'(shadow_cfg.time_headway)) / 256
             + extra;
      if (want < longint'(shadow_cfg.min_gap)) want = shadow_cfg.min_gap;
      // Speed ratio raised to the exponent, capped at 2^32 after each step.
      v0 = (shadow_cfg.desired_speed != 0) ? longint'(shadow_cfg.desired_speed) : 1;
      p = 65536;
      for (int i = 0; i < shadow_cfg.speed_exponent; i++) begin
         p = (p * v) / v0;
         if (p > 64'sd4294967296) p = 64'sd4294967296;
      end
      // Squared ratio of desired to actual gap.
      r = (want * 65536) / gap;
      if (r > (64'sd1 << 24)) q = 64'sd4294967296;
      else begin
         q = (r * r) / 65536;
         if (q > 64'sd4294967296) q = 64'sd4294967296;
      end
      acc = (longint'(shadow_cfg.max_accel) * (65536 - p - q)) / 65536;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      w.accel = acc[15:0];
      w.fault = 1'b0;
      return w;
   endfunction

   // Sends one vehicle-pair word, honoring the sender idle percentage, and
   // records the expected result when the word is accepted. The push stays
   // high afterwards so the next word can follow at once.
   task automatic send_pair(input logic [15:0] v, input logic present,
                            input logic [15:0] vl, input logic signed [31:0] own_x,
                            input logic signed [31:0] lead_x, input logic reverse,
                            input logic [15:0] length);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_own_speed <= v;
      req_leader_present <= present;
      req_leader_speed <= vl;
      req_own_position <= own_x;
      req_leader_position <= lead_x;
      req_travel_reverse <= reverse;
      req_own_length <= length;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pending_accel.push_back(model_accel(v, present, vl, own_x, lead_x, reverse, length));
   endtask

   // Waits until every expected word has come back, then lets the back end
   // drain anything still in flight before the registers may change.
   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_accel.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [15:0] data);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_DESIRED_SPEED:  shadow_cfg.desired_speed = data;
         REG_SPEED_EXPONENT: shadow_cfg.speed_exponent = data[3:0];
         REG_MAX_ACCEL:      shadow_cfg.max_accel = data;
         REG_MIN_GAP:        shadow_cfg.min_gap = data;
         REG_TIME_HEADWAY:   shadow_cfg.time_headway = data;
         REG_COMFORT_TERM:   shadow_cfg.comfort_term = data;
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [15:0] ds, input logic [3:0] ex,
                              input logic [15:0] ma, input logic [15:0] mg,
                              input logic [15:0] th, input logic [15:0] ct);
      write_reg(REG_DESIRED_SPEED, ds);
      write_reg(REG_SPEED_EXPONENT, {12'd0, ex});
      write_reg(REG_MAX_ACCEL, ma);
      write_reg(REG_MIN_GAP, mg);
      write_reg(REG_TIME_HEADWAY, th);
      write_reg(REG_COMFORT_TERM, ct);
      csr_we <= 1'b0;
   endtask

   // A random but mostly realistic vehicle pair: small positive gaps, speeds
   // around the desired speed, with occasional full-range words mixed in.
   task automatic send_random_pair();
      logic [15:0] v, vl, length;
      logic signed [31:0] own_x, span;
      logic present, reverse;
      v = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(12000, 0));
      vl = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(12000, 0));
      length = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(1500, 0));
      present = ($urandom_range(4, 0) != 0);
      reverse = 1'($urandom_range(1, 0));
      own_x = $urandom;
      case ($urandom_range(5, 0))
         0: span = $urandom;
         1: span = 32'($urandom_range(2000, 0)) - 1000;
         default: span = 32'($urandom_range(200000, 0));
      endcase
      send_pair(v, present, vl, own_x, reverse ? own_x - span : own_x + span, reverse,
                length);
   endtask

   task automatic test_directed_cases();
      // Free road at rest, at 30 m/s and at full speed; the leader fields are ignored.
      send_pair(16'd0, 1'b0, 16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1'b1, 16'hFFFF);
      send_pair(16'hFFFF, 1'b0, 16'd0, 32'sd0, 32'sd0, 1'b0, 16'd0);
      send_pair(16'd7680, 1'b0, 16'd0, 32'sd0, 32'sd0, 1'b0, 16'd0);
      // Leader ahead, forward and reverse travel.
      send_pair(16'd5000, 1'b1, 16'd4000, 32'sd1000, 32'sd20000, 1'b0, 16'd1200);
      send_pair(16'd5000, 1'b1, 16'd6000, 32'sd20000, 32'sd1000, 1'b1, 16'd1200);
      // Gap exactly zero, one, and negative.
      send_pair(16'd100, 1'b1, 16'd100, 32'sd0, 32'sd1200, 1'b0, 16'd1200);
      send_pair(16'd100, 1'b1, 16'd100, 32'sd0, 32'sd1201, 1'b0, 16'd1200);
      send_pair(16'd100, 1'b1, 16'd100, 32'sd5000, 32'sd0, 1'b0, 16'd0);
      // Position extremes in both directions.
      send_pair(16'hFFFF, 1'b1, 16'd0, 32'sh80000000, 32'sh7FFFFFFF, 1'b0, 16'hFFFF);
      send_pair(16'hFFFF, 1'b1, 16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1'b1, 16'd0);
      send_pair(16'd0, 1'b1, 16'hFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1, 16'd0);
      // Closing fast on a slow leader: large desired gap, strong braking.
      send_pair(16'd9000, 1'b1, 16'd0, 32'sd0, 32'sd3000, 1'b0, 16'd500);
      // Leader pulling away, and both at rest: desired gap at the minimum.
      send_pair(16'd3000, 1'b1, 16'hFFFF, 32'sd0, 32'sd50000, 1'b0, 16'd500);
      send_pair(16'd0, 1'b1, 16'd0, 32'sd0, 32'sd700, 1'b0, 16'd0);
   endtask

   task automatic test_config_extremes();
      drain_results();
      // Zero desired speed and zero comfort term act as one; exponent zero
      // makes the speed term exactly one.
      load_config(16'd0, 4'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
      test_directed_cases();
      drain_results();
      load_config(16'hFFFF, 4'd15, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      test_directed_cases();
      drain_results();
      load_config(16'd1, 4'd8, 16'd1, 16'd1, 16'd1, 16'd1);
      test_directed_cases();
      drain_results();
   endtask

   task automatic test_random_traffic(input int count, input int idle, input int stall);
      send_idle_pct = idle;
      pop_stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         send_random_pair();
         // Now and then let the core run completely dry before the next word.
         if ($urandom_range(99, 0) == 0) drain_results();
      end
      drain_results();
      send_idle_pct = 0;
      pop_stall_pct = 0;
   endtask

   task automatic test_random_config();
      load_config(16'($urandom_range(65535, 1)), 4'($urandom_range(8, 1)), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)));
   endtask

   // Result checker: pops with a random stall and compares each word with the
   // oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_accel.size() == 0) begin
               failures++;
               $display("%0t unexpected word: accel %0d fault %0b", $time,
                        rsp_accel_out, rsp_gap_fault);
            end else begin
               if (rsp_accel_out !== pending_accel[0].accel) begin
                  failures++;
                  $display("%0t accel_out mismatch: expected %0d actual %0d", $time,
                           pending_accel[0].accel, rsp_accel_out);
               end
               if (rsp_gap_fault !== pending_accel[0].fault) begin
                  failures++;
                  $display("%0t gap_fault mismatch: expected %0b actual %0b", $time,
                           pending_accel[0].fault, rsp_gap_fault);
               end
               void'(pending_accel.pop_front());
            end
         end
         rsp_pop <= ($urandom_range(99, 0) >= pop_stall_pct);
      end
   end

   initial begin
      shadow_cfg = '{RST_DESIRED_SPEED, RST_SPEED_EXPONENT, RST_MAX_ACCEL, RST_MIN_GAP,
                     RST_TIME_HEADWAY, RST_COMFORT_TERM};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_config_extremes();
      load_config(RST_DESIRED_SPEED, RST_SPEED_EXPONENT, RST_MAX_ACCEL, RST_MIN_GAP,
                  RST_TIME_HEADWAY, RST_COMFORT_TERM);
      test_random_traffic(225, 0, 0);
      test_random_config();
      test_random_traffic(225, 46, 0);
      test_random_config();
      test_random_traffic(225, 0, 46);
      test_random_config();
      test_random_traffic(225, 19, 19);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Worst case is roughly 1000 words, each at the slowest speed exponent, plus stalls.
   initial begin
      #(8 * 5000000);
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire
